// ===== rtl/core/date_text_to_epoch_seconds_defines.svh =====
`ifndef DATE_TEXT_TO_EPOCH_SECONDS_DEFINES_SVH
`define DATE_TEXT_TO_EPOCH_SECONDS_DEFINES_SVH

// Checks a consequence in the same cycle as its cause.
`define DTES_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks a consequence in the cycle after its cause.
`define DTES_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/dtes_pkg.sv =====
package dtes_pkg;

	localparam int FieldW    = 7;
	localparam int YearW     = 14;
	localparam int PivotW    = 7;
	localparam int EpochW    = 39;
	localparam int HmsW      = 17;
	localparam logic [PivotW-1:0] PivotReset = 7'd30;

	// Number of arithmetic cycles between the final byte and the result load.
	localparam int CalcCycles = 7;
	localparam int CntW       = 3;

	typedef enum logic [4:0] {
		PH_FRESH, PH_LEAD, PH_NOW, PH_MON, PH_DAY0, PH_DAY, PH_YEAR0, PH_YEAR,
		PH_SP1, PH_HOUR, PH_MIN0, PH_MIN, PH_SP2, PH_SEC0, PH_SEC, PH_AM, PH_PM,
		PH_TAIL
	} phase_t;

	typedef enum logic [1:0] {
		CS_TEXT,
		CS_CALC,
		CS_LOAD
	} ctrl_state_t;

	typedef enum logic [1:0] {
		PS_VALID   = 2'd0,
		PS_INVALID = 2'd1,
		PS_NOW     = 2'd2
	} status_t;

	typedef struct packed {
		logic take;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic out_full;
	} dp_stat_t;

	// Days before the first of a month, counted in a year that starts in March.
	function automatic logic [8:0] month_offset(input logic [FieldW-1:0] m);
		logic [8:0] r;
		case (m)
			7'd3:    r = 9'd0;
			7'd4:    r = 9'd31;
			7'd5:    r = 9'd61;
			7'd6:    r = 9'd92;
			7'd7:    r = 9'd122;
			7'd8:    r = 9'd153;
			7'd9:    r = 9'd184;
			7'd10:   r = 9'd214;
			7'd11:   r = 9'd245;
			7'd12:   r = 9'd275;
			7'd1:    r = 9'd306;
			7'd2:    r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] month_days(input logic [FieldW-1:0] m, input logic leap);
		logic [4:0] r;
		case (m)
			7'd2:    r = leap ? 5'd29 : 5'd28;
			7'd4:    r = 5'd30;
			7'd6:    r = 5'd30;
			7'd9:    r = 5'd30;
			7'd11:   r = 5'd30;
			default: r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/dtes_ctrl.sv =====
module dtes_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               last_char,
	input  logic               out_ready,
	input  dtes_pkg::dp_stat_t stat,
	output logic               in_ready,
	output dtes_pkg::dp_cmd_t  cmd
);

	localparam logic [dtes_pkg::CntW-1:0] LastStep = dtes_pkg::CntW'(dtes_pkg::CalcCycles - 1);

	dtes_pkg::ctrl_state_t state_q, state_n;
	logic [dtes_pkg::CntW-1:0] cnt_q;
	logic can_load;

	assign can_load = !stat.out_full || out_ready;

	always_comb begin
		state_n = state_q;
		case (state_q)
			dtes_pkg::CS_TEXT: begin
				if (in_valid && last_char) begin
					state_n = dtes_pkg::CS_CALC;
				end
			end
			dtes_pkg::CS_CALC: begin
				if (cnt_q == LastStep) begin
					state_n = dtes_pkg::CS_LOAD;
				end
			end
			dtes_pkg::CS_LOAD: begin
				if (can_load) begin
					state_n = dtes_pkg::CS_TEXT;
				end
			end
			default: state_n = dtes_pkg::CS_TEXT;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == dtes_pkg::CS_TEXT);
		cmd.take     = in_ready && in_valid;
		cmd.load_out = (state_q == dtes_pkg::CS_LOAD) && can_load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtes_pkg::CS_TEXT;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == dtes_pkg::CS_CALC) begin
				cnt_q <= cnt_q + dtes_pkg::CntW'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

endmodule

// ===== rtl/core/dtes_dp.sv =====
module dtes_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [dtes_pkg::PivotW-1:0]   cfg_data,
	input  logic [7:0]                    char_byte,
	input  dtes_pkg::dp_cmd_t             cmd,
	input  logic                          out_ready,
	output dtes_pkg::dp_stat_t            stat,
	output logic                          out_valid,
	output logic [1:0]                    parse_status,
	output logic signed [dtes_pkg::EpochW-1:0] epoch_seconds
);

	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChSlash = 8'h2F;
	localparam logic [7:0] ChColon = 8'h3A;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChNLo   = 8'h6E;
	localparam logic [7:0] ChOLo   = 8'h6F;
	localparam logic [7:0] ChWLo   = 8'h77;
	localparam logic [7:0] ChALo   = 8'h61;
	localparam logic [7:0] ChAUp   = 8'h41;
	localparam logic [7:0] ChPLo   = 8'h70;
	localparam logic [7:0] ChPUp   = 8'h50;
	localparam logic [7:0] ChMLo   = 8'h6D;
	localparam logic [7:0] ChMUp   = 8'h4D;

	localparam int FW = dtes_pkg::FieldW;
	localparam int YW = dtes_pkg::YearW;

	// Text parser state.
	dtes_pkg::phase_t phase_q, ph_n;
	logic [2:0]    dc_q, dc_n;
	logic [FW-1:0] mon_q, mon_n, day_q, day_n, hour_q, hr_n, min_q, mi_n, sec_q, se_n;
	logic [YW-1:0] year_q, yr_n, year_adj;
	logic          valid_q;
	logic [1:0]    nowp_q, nowp_n;
	logic          ok;
	logic [dtes_pkg::PivotW-1:0] pivot_q;

	logic       is_dig, sp;
	logic [3:0] dig;

	assign is_dig   = (char_byte >= ChZero) && (char_byte <= ChNine);
	assign sp       = (char_byte == ChSpace);
	assign dig      = char_byte[3:0];
	assign year_adj = year_q + ((year_q <= {7'b0, pivot_q}) ? 14'd2000 : 14'd1900);

	always_comb begin
		ph_n   = phase_q;
		dc_n   = dc_q;
		mon_n  = mon_q;
		day_n  = day_q;
		yr_n   = year_q;
		hr_n   = hour_q;
		mi_n   = min_q;
		se_n   = sec_q;
		nowp_n = nowp_q;
		ok     = 1'b0;
		case (phase_q)
			dtes_pkg::PH_FRESH, dtes_pkg::PH_LEAD: begin
				if (phase_q == dtes_pkg::PH_FRESH && char_byte == ChNLo) begin
					nowp_n = 2'd1;
					ph_n   = dtes_pkg::PH_NOW;
					ok     = 1'b1;
				end else if (sp) begin
					ph_n = dtes_pkg::PH_LEAD;
					ok   = 1'b1;
				end else if (is_dig) begin
					mon_n = {3'b0, dig};
					dc_n  = 3'd1;
					ph_n  = dtes_pkg::PH_MON;
					ok    = 1'b1;
				end
			end
			dtes_pkg::PH_NOW: begin
				if (nowp_q == 2'd1 && char_byte == ChOLo) begin
					nowp_n = 2'd2;
					ok     = 1'b1;
				end else if (nowp_q == 2'd2 && char_byte == ChWLo) begin
					nowp_n = 2'd3;
					ok     = 1'b1;
				end else begin
					nowp_n = 2'd0;
				end
			end
			dtes_pkg::PH_MON: begin
				if (char_byte == ChSlash) begin
					ph_n = dtes_pkg::PH_DAY0;
					ok   = 1'b1;
				end else if (is_dig && dc_q < 3'd2) begin
					mon_n = mon_q * 7'd10 + {3'b0, dig};
					dc_n  = dc_q + 3'd1;
					ok    = 1'b1;
				end
			end
			dtes_pkg::PH_DAY0: begin
				if (is_dig) begin
					day_n = {3'b0, dig};
					dc_n  = 3'd1;
					ph_n  = dtes_pkg::PH_DAY;
					ok    = 1'b1;
				end
			end
			dtes_pkg::PH_DAY: begin
				if (char_byte == ChSlash) begin
					ph_n = dtes_pkg::PH_YEAR0;
					ok   = 1'b1;
				end else if (is_dig && dc_q < 3'd2) begin
					day_n = day_q * 7'd10 + {3'b0, dig};
					dc_n  = dc_q + 3'd1;
					ok    = 1'b1;
				end
			end
			dtes_pkg::PH_YEAR0: begin
				if (is_dig) begin
					yr_n = {10'b0, dig};
					dc_n = 3'd1;
					ph_n = dtes_pkg::PH_YEAR;
					ok   = 1'b1;
				end
			end
			dtes_pkg::PH_YEAR: begin
				if (sp) begin
					ph_n = dtes_pkg::PH_SP1;
					if (dc_q == 3'd2) begin
						yr_n = year_adj;
						ok   = 1'b1;
					end else begin
						ok = (dc_q == 3'd4);
					end
				end else if (is_dig && dc_q < 3'd4) begin
					yr_n = year_q * 14'd10 + {10'b0, dig};
					dc_n = dc_q + 3'd1;
					ok   = 1'b1;
				end
			end
			dtes_pkg::PH_SP1: begin
				if (sp) begin
					ok = 1'b1;
				end else if (is_dig) begin
					hr_n = {3'b0, dig};
					dc_n = 3'd1;
					ph_n = dtes_pkg::PH_HOUR;
					ok   = 1'b1;
				end
			end
			dtes_pkg::PH_HOUR: begin
				if (char_byte == ChColon) begin
					ph_n = dtes_pkg::PH_MIN0;
					ok   = 1'b1;
				end else if (is_dig && dc_q < 3'd2) begin
					hr_n = hour_q * 7'd10 + {3'b0, dig};
					dc_n = dc_q + 3'd1;
					ok   = 1'b1;
				end
			end
			dtes_pkg::PH_MIN0: begin
				if (is_dig) begin
					mi_n = {3'b0, dig};
					dc_n = 3'd1;
					ph_n = dtes_pkg::PH_MIN;
					ok   = 1'b1;
				end
			end
			dtes_pkg::PH_MIN, dtes_pkg::PH_SP2: begin
				if (sp) begin
					ph_n = dtes_pkg::PH_SP2;
					ok   = 1'b1;
				end else if (char_byte == ChALo || char_byte == ChAUp) begin
					ph_n = dtes_pkg::PH_AM;
					ok   = 1'b1;
				end else if (char_byte == ChPLo || char_byte == ChPUp) begin
					ph_n = dtes_pkg::PH_PM;
					ok   = 1'b1;
				end else if (phase_q == dtes_pkg::PH_MIN) begin
					if (char_byte == ChColon) begin
						ph_n = dtes_pkg::PH_SEC0;
						ok   = 1'b1;
					end else if (is_dig && dc_q < 3'd2) begin
						mi_n = min_q * 7'd10 + {3'b0, dig};
						dc_n = dc_q + 3'd1;
						ok   = 1'b1;
					end
				end
			end
			dtes_pkg::PH_SEC0: begin
				if (is_dig) begin
					se_n = {3'b0, dig};
					dc_n = 3'd1;
					ph_n = dtes_pkg::PH_SEC;
					ok   = 1'b1;
				end
			end
			dtes_pkg::PH_SEC: begin
				if (sp) begin
					ph_n = dtes_pkg::PH_TAIL;
					ok   = 1'b1;
				end else if (is_dig && dc_q < 3'd2) begin
					se_n = sec_q * 7'd10 + {3'b0, dig};
					dc_n = dc_q + 3'd1;
					ok   = 1'b1;
				end
			end
			dtes_pkg::PH_AM, dtes_pkg::PH_PM: begin
				if ((char_byte == ChMLo || char_byte == ChMUp) &&
				    hour_q >= 7'd1 && hour_q <= 7'd12) begin
					hr_n = ((hour_q == 7'd12) ? 7'd0 : hour_q) +
					       ((phase_q == dtes_pkg::PH_PM) ? 7'd12 : 7'd0);
					ph_n = dtes_pkg::PH_TAIL;
					ok   = 1'b1;
				end
			end
			dtes_pkg::PH_TAIL: ok = sp;
			default:           ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pivot_q <= dtes_pkg::PivotReset;
		end else if (cfg_valid) begin
			pivot_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dtes_pkg::PH_FRESH;
			dc_q    <= '0;
			mon_q   <= '0;
			day_q   <= '0;
			year_q  <= '0;
			hour_q  <= '0;
			min_q   <= '0;
			sec_q   <= '0;
			valid_q <= 1'b1;
			nowp_q  <= '0;
		end else if (cmd.load_out) begin
			phase_q <= dtes_pkg::PH_FRESH;
			dc_q    <= '0;
			mon_q   <= '0;
			day_q   <= '0;
			year_q  <= '0;
			hour_q  <= '0;
			min_q   <= '0;
			sec_q   <= '0;
			valid_q <= 1'b1;
			nowp_q  <= '0;
		end else if (cmd.take && valid_q) begin
			phase_q <= ph_n;
			dc_q    <= dc_n;
			mon_q   <= mon_n;
			day_q   <= day_n;
			year_q  <= yr_n;
			hour_q  <= hr_n;
			min_q   <= mi_n;
			sec_q   <= se_n;
			valid_q <= ok;
			nowp_q  <= nowp_n;
		end
	end

	// Stage 1: form of the text, effective year, time of day.
	logic form_ok_c, is_now_c, time_ok_c;
	logic [YW-1:0] y_c;
	logic [dtes_pkg::HmsW-1:0] hms_c;

	assign form_ok_c = valid_q &&
		((phase_q == dtes_pkg::PH_YEAR) ? (dc_q == 3'd2 || dc_q == 3'd4) :
		 (phase_q == dtes_pkg::PH_SP1 || phase_q == dtes_pkg::PH_MIN ||
		  phase_q == dtes_pkg::PH_SP2 || phase_q == dtes_pkg::PH_SEC ||
		  phase_q == dtes_pkg::PH_TAIL));
	assign is_now_c  = valid_q && phase_q == dtes_pkg::PH_NOW && nowp_q == 2'd3;
	assign y_c       = (phase_q == dtes_pkg::PH_YEAR && dc_q == 3'd2) ? year_adj : year_q;
	assign time_ok_c = hour_q <= 7'd23 && min_q <= 7'd59 && sec_q <= 7'd59;
	assign hms_c     = {10'b0, hour_q} * 17'd3600 + {10'b0, min_q} * 17'd60 + {10'b0, sec_q};

	logic [YW-1:0] y_s1;
	logic [FW-1:0] m_s1, d_s1;
	logic form_ok_s1, now_s1, time_ok_s1;
	logic [dtes_pkg::HmsW-1:0] hms_s1;

	always_ff @(posedge clk) begin
		y_s1       <= y_c;
		m_s1       <= mon_q;
		d_s1       <= day_q;
		form_ok_s1 <= form_ok_c;
		now_s1     <= is_now_c;
		time_ok_s1 <= time_ok_c;
		hms_s1     <= hms_c;
	end

	// Stage 2: shifted year and the year divided by 100.
	logic [YW-1:0] yy_c;
	logic [22:0]   q_prod;

	assign yy_c   = y_s1 + 14'd400 - {13'b0, (m_s1 <= 7'd2)};
	assign q_prod = {11'b0, y_s1[13:2]} * 23'd1311;

	logic [YW-1:0] yy_s2, y_s2;
	logic [6:0]    q100_s2;
	logic [FW-1:0] m_s2, d_s2;
	logic form_ok_s2, now_s2, time_ok_s2;
	logic [dtes_pkg::HmsW-1:0] hms_s2;

	always_ff @(posedge clk) begin
		yy_s2      <= yy_c;
		q100_s2    <= q_prod[21:15];
		y_s2       <= y_s1;
		m_s2       <= m_s1;
		d_s2       <= d_s1;
		form_ok_s2 <= form_ok_s1;
		now_s2     <= now_s1;
		time_ok_s2 <= time_ok_s1;
		hms_s2     <= hms_s1;
	end

	// Stage 3: era, leap year, range checks, day of the March-based year.
	logic [14:0] era_prod;
	logic        m100, leap, range_ok;
	logic [4:0]  dim;
	logic [8:0]  doy_c;
	dtes_pkg::status_t status_c;

	assign era_prod = {5'b0, yy_s2[13:4]} * 15'd41;
	assign m100     = (y_s2 == {7'b0, q100_s2} * 14'd100);
	assign leap     = (y_s2[1:0] == 2'd0 && !m100) || (m100 && q100_s2[1:0] == 2'd0);
	assign dim      = dtes_pkg::month_days(m_s2, leap);
	assign range_ok = m_s2 >= 7'd1 && m_s2 <= 7'd12 && d_s2 >= 7'd1 &&
	                  d_s2 <= {2'b0, dim} && time_ok_s2;
	assign status_c = now_s2 ? dtes_pkg::PS_NOW :
	                  (form_ok_s2 && range_ok) ? dtes_pkg::PS_VALID : dtes_pkg::PS_INVALID;
	assign doy_c    = dtes_pkg::month_offset(m_s2) + {2'b0, d_s2} - 9'd1;

	logic [4:0]    era_s3;
	logic [YW-1:0] yy_s3;
	logic [8:0]    doy_s3;
	dtes_pkg::status_t status_s3;
	logic [dtes_pkg::HmsW-1:0] hms_s3;

	always_ff @(posedge clk) begin
		era_s3    <= era_prod[14:10];
		yy_s3     <= yy_s2;
		doy_s3    <= doy_c;
		status_s3 <= status_c;
		hms_s3    <= hms_s2;
	end

	// Stage 4: year of era and the era's day count.
	logic [YW-1:0] yoe_full;

	assign yoe_full = yy_s3 - {9'b0, era_s3} * 14'd400;

	logic [8:0]  yoe_s4, doy_s4;
	logic [21:0] eraterm_s4;
	dtes_pkg::status_t status_s4;
	logic [dtes_pkg::HmsW-1:0] hms_s4;

	always_ff @(posedge clk) begin
		yoe_s4     <= yoe_full[8:0];
		eraterm_s4 <= {17'b0, era_s3} * 22'd146097;
		doy_s4     <= doy_s3;
		status_s4  <= status_s3;
		hms_s4     <= hms_s3;
	end

	// Stage 5: day of era.
	logic [1:0]  div100;
	logic [17:0] doe_c;

	assign div100 = (yoe_s4 >= 9'd300) ? 2'd3 : (yoe_s4 >= 9'd200) ? 2'd2 :
	                (yoe_s4 >= 9'd100) ? 2'd1 : 2'd0;
	assign doe_c  = {9'b0, yoe_s4} * 18'd365 + {11'b0, yoe_s4[8:2]} - {16'b0, div100} +
	                {9'b0, doy_s4};

	logic [17:0] doe_s5;
	logic [21:0] eraterm_s5;
	dtes_pkg::status_t status_s5;
	logic [dtes_pkg::HmsW-1:0] hms_s5;

	always_ff @(posedge clk) begin
		doe_s5     <= doe_c;
		eraterm_s5 <= eraterm_s4;
		status_s5  <= status_s4;
		hms_s5     <= hms_s4;
	end

	// Stage 6: days since 1970-01-01, removing the 400-year shift.
	logic signed [23:0] days_s6;
	dtes_pkg::status_t status_s6;
	logic [dtes_pkg::HmsW-1:0] hms_s6;

	always_ff @(posedge clk) begin
		days_s6   <= $signed({2'b0, eraterm_s5}) + $signed({6'b0, doe_s5}) - 24'sd865565;
		status_s6 <= status_s5;
		hms_s6    <= hms_s5;
	end

	// Stage 7: days to seconds.
	logic signed [dtes_pkg::EpochW-1:0] prod_s7;
	dtes_pkg::status_t status_s7;
	logic [dtes_pkg::HmsW-1:0] hms_s7;

	always_ff @(posedge clk) begin
		prod_s7   <= $signed({{15{days_s6[23]}}, days_s6}) * 39'sd86400;
		status_s7 <= status_s6;
		hms_s7    <= hms_s6;
	end

	// Result register.
	logic signed [dtes_pkg::EpochW-1:0] secs_c, epoch_q;
	dtes_pkg::status_t status_q;
	logic out_valid_q;

	assign secs_c = prod_s7 + $signed({22'b0, hms_s7});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status_q <= status_s7;
			epoch_q  <= (status_s7 == dtes_pkg::PS_VALID) ? secs_c : '0;
		end
	end

	assign stat.out_full = out_valid_q;
	assign out_valid     = out_valid_q;
	assign parse_status  = status_q;
	assign epoch_seconds = epoch_q;

endmodule

// ===== rtl/core/date_text_to_epoch_seconds.sv =====
// Channel  | Signals                                   | Transfer when
// ---------+-------------------------------------------+------------------------
// in       | in_valid, in_ready, char_byte, last_char  | in_valid && in_ready
// out      | out_valid, out_ready, parse_status,       | out_valid && out_ready
//          | epoch_seconds                             |
// cfg      | cfg_valid, cfg_ready, two_digit_year_pivot| cfg_valid && cfg_ready
//
// Characters are taken one per cycle while a text is being parsed.
// The final character's transfer starts the conversion; the result register is then loaded.
// The conversion runs through a chain of registered stages, one multiply or wide add each.
// A result waiting in the output register does not block the next text; only a second
// result finding the register still full stalls the load, and input stays closed meanwhile.
// Reset is asynchronous and active low; it restores the pivot to 30 and clears the parser.

`include "date_text_to_epoch_seconds_defines.svh"

module date_text_to_epoch_seconds (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [7:0]                           char_byte,
	input  logic                                 last_char,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [1:0]                           parse_status,
	output logic signed [dtes_pkg::EpochW-1:0]   epoch_seconds,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dtes_pkg::PivotW-1:0]          two_digit_year_pivot
);

	dtes_pkg::dp_cmd_t  cmd;
	dtes_pkg::dp_stat_t stat;

	// The pivot register accepts a write in any cycle.
	assign cfg_ready = 1'b1;

	// The controller sequences text intake, the conversion, and the result load.
	dtes_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_char (last_char),
		.out_ready (out_ready),
		.stat      (stat),
		.in_ready  (in_ready),
		.cmd       (cmd)
	);

	// The datapath holds the parser, the calendar arithmetic and the result register.
	dtes_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_data      (two_digit_year_pivot),
		.char_byte     (char_byte),
		.cmd           (cmd),
		.out_ready     (out_ready),
		.stat          (stat),
		.out_valid     (out_valid),
		.parse_status  (parse_status),
		.epoch_seconds (epoch_seconds)
	);

	// Only a valid date carries a nonzero seconds value.
	`DTES_ASSERT_SAME(a_zero_unless_valid, out_valid && parse_status != dtes_pkg::PS_VALID, epoch_seconds == '0, "seconds nonzero on a non-date result")

	// The final character closes the input for the conversion.
	`DTES_ASSERT_NEXT(a_busy_after_last, in_valid && in_ready && last_char, !in_ready, "input still open after final character")

	// A result load always presents a result.
	`DTES_ASSERT_NEXT(a_load_fills_out, cmd.load_out, out_valid, "result load did not raise out_valid")

endmodule
